### sv/miller_rabin_prime_test_defines.svh
// Assertion macros shared by the primality tester modules
`ifndef MILLER_RABIN_PRIME_TEST_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MRPT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MRPT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mrpt_pkg.sv
// Package: types, constants and helpers of the primality tester
package mrpt_pkg;

  localparam int unsigned NUM_WIDTH_DEF = 32;

  localparam logic [7:0] BASE_FIRST  = 8'd2;
  localparam logic [7:0] BASE_SECOND = 8'd7;
  localparam logic [7:0] BASE_THIRD  = 8'd61;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE,
    S_MOD3,
    S_SPLIT,
    S_BASE,
    S_EXP_SQ,
    S_W_SQ,
    S_EXP_MUL,
    S_W_MUL,
    S_EXP_NEXT,
    S_CHK,
    S_LP_TEST,
    S_W_LP,
    S_NEXT_BASE,
    S_DONE
  } mrpt_state_e;

  typedef enum logic [1:0] {
    BASE_SEL_2,
    BASE_SEL_7,
    BASE_SEL_61
  } mrpt_base_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mrpt_mm_stat_t;

  function automatic logic [7:0] base_value(mrpt_base_e sel);
    logic [7:0] v;
    case (sel)
      BASE_SEL_2:  v = BASE_FIRST;
      BASE_SEL_7:  v = BASE_SECOND;
      BASE_SEL_61: v = BASE_THIRD;
      default:     v = BASE_FIRST;
    endcase
    return v;
  endfunction

  // residue mod 3: 4 is 1 mod 3, so 2-bit digits are summed and the sum folded
  function automatic logic [1:0] mod3_of(logic [31:0] v);
    logic [3:0][3:0] grp;
    logic [5:0]      acc;
    logic [3:0]      f1;
    logic [2:0]      f2;
    for (int g = 0; g < 4; g++) begin
      grp[g] = 4'(v[8*g +: 2]) + 4'(v[8*g+2 +: 2]) + 4'(v[8*g+4 +: 2]) + 4'(v[8*g+6 +: 2]);
    end
    acc = 6'(grp[0]) + 6'(grp[1]) + 6'(grp[2]) + 6'(grp[3]);
    f1  = 4'(acc[1:0]) + 4'(acc[3:2]) + 4'(acc[5:4]);
    f2  = 3'(f1[1:0]) + 3'(f1[3:2]);
    return (f2 >= 3'd3) ? 2'(f2 - 3'd3) : f2[1:0];
  endfunction

endpackage

### sv/mrpt_modmul.sv
// Bit-serial modular multiplier: a * b mod n, one bit of b per cycle
`include "miller_rabin_prime_test_defines.svh"

module mrpt_modmul import mrpt_pkg::*; #(
  parameter int unsigned NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_WIDTH-1:0] a_i,
  input  logic [NUM_WIDTH-1:0] b_i,
  input  logic [NUM_WIDTH-1:0] n_i,
  output logic [NUM_WIDTH-1:0] prod_o,
  output mrpt_mm_stat_t        stat_o
);

  localparam int unsigned CW = $clog2(NUM_WIDTH + 1);

  logic [NUM_WIDTH-1:0] a_q, a_d;
  logic [NUM_WIDTH-1:0] b_q, b_d;
  logic [NUM_WIDTH-1:0] r_q, r_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [NUM_WIDTH:0] n_ext;
  logic [NUM_WIDTH:0] dbl;
  logic [NUM_WIDTH:0] red1;
  logic [NUM_WIDTH:0] sum;
  logic [NUM_WIDTH:0] red2;

  always_comb begin
    n_ext = {1'b0, n_i};
    dbl   = {r_q, 1'b0};
    red1  = (dbl >= n_ext) ? (dbl - n_ext) : dbl;
    sum   = red1 + (b_q[NUM_WIDTH-1] ? {1'b0, a_q} : '0);
    red2  = (sum >= n_ext) ? (sum - n_ext) : sum;
  end

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      r_d    = '0;
      cnt_d  = CW'(NUM_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = red2[NUM_WIDTH-1:0];
      b_d   = b_q << 1;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign prod_o      = r_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `MRPT_ASSERT_IMP(a_mm_reduced, done_q, r_q < n_i, "product not reduced")
  `MRPT_ASSERT_NXT(a_mm_start_busy, start_i, busy_q, "start did not raise busy")
  `MRPT_ASSERT_IMP(a_mm_done_after_busy, done_q, $past(busy_q), "done without busy")

endmodule

### sv/miller_rabin_prime_test.sv
// Top level: Miller-Rabin primality tester with a shared modular multiplier
//
// Input channel: candidate_i with in_valid_i; the block raises in_stall_o
// while it works on a candidate, so one candidate is in flight at a time.
// Output channel: is_prime_o with out_valid_o; the receiver holds it with
// out_stall_i. The result sits in an output register, so the next candidate
// is taken the cycle after the previous result is registered, even while stalled.
// Path to out_valid_o: 0, 1, 2, 3 and even values are decided in the
// pre-check; other multiples of 3 in the mod-3 check; otherwise the
// trailing-zero split and, per base, up to 2 * NUM_WIDTH - 1 products,
// all on the one bit-serial modular multiplier, for up to three bases.
// A finished result waits in the tester when the output register is still
// full and stalled. Reset empties the output register and returns to idle.

`include "miller_rabin_prime_test_defines.svh"

module miller_rabin_prime_test import mrpt_pkg::*; #(
  parameter int unsigned NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [NUM_WIDTH-1:0] candidate_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 is_prime_o
);

  localparam int unsigned CW = $clog2(NUM_WIDTH + 1);

  mrpt_state_e state_q, state_d;
  mrpt_base_e  base_q, base_d;

  logic [NUM_WIDTH-1:0] n_q, n_d;
  logic [NUM_WIDTH-1:0] d_q, d_d;
  logic [NUM_WIDTH-1:0] x_q, x_d;
  logic [NUM_WIDTH-1:0] e_q, e_d;
  logic [CW-1:0]        s_q, s_d;
  logic [CW-1:0]        i_q, i_d;
  logic [CW-1:0]        j_q, j_d;
  logic                 res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_prime_q, out_prime_d;

  logic                 mm_start;
  logic [NUM_WIDTH-1:0] mm_b;
  logic [NUM_WIDTH-1:0] mm_prod;
  mrpt_mm_stat_t        mm_stat;
  logic [NUM_WIDTH-1:0] nm1;
  logic [1:0]           n_mod3;

  mrpt_modmul #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .a_i    (x_q),
    .b_i    (mm_b),
    .n_i    (n_q),
    .prod_o (mm_prod),
    .stat_o (mm_stat)
  );

  assign nm1    = n_q - NUM_WIDTH'(1);
  assign n_mod3 = mod3_of(32'(n_q));

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    n_d         = n_q;
    d_d         = d_q;
    x_d         = x_q;
    e_d         = e_q;
    s_d         = s_q;
    i_d         = i_q;
    j_d         = j_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_prime_d = out_prime_q;
    mm_start    = 1'b0;
    mm_b        = x_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          n_d     = candidate_i;
          state_d = S_PRE;
        end
      end
      S_PRE: begin
        if (n_q == NUM_WIDTH'(2) || n_q == NUM_WIDTH'(3)) begin
          res_d   = 1'b1;
          state_d = S_DONE;
        end else if (n_q < NUM_WIDTH'(2) || !n_q[0]) begin
          res_d   = 1'b0;
          state_d = S_DONE;
        end else begin
          base_d  = BASE_SEL_2;
          state_d = S_MOD3;
        end
      end
      S_MOD3: begin
        if (n_mod3 == 2'd0) begin
          res_d   = 1'b0;
          state_d = S_DONE;
        end else begin
          d_d     = nm1;
          s_d     = '0;
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (!d_q[0]) begin
          d_d = d_q >> 1;
          s_d = s_q + CW'(1);
        end else begin
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        x_d     = NUM_WIDTH'(1);
        e_d     = d_q;
        i_d     = CW'(NUM_WIDTH);
        state_d = S_EXP_SQ;
      end
      S_EXP_SQ: begin
        mm_start = 1'b1;
        state_d  = S_W_SQ;
      end
      S_W_SQ: begin
        if (mm_stat.done) begin
          x_d     = mm_prod;
          state_d = e_q[NUM_WIDTH-1] ? S_EXP_MUL : S_EXP_NEXT;
        end
      end
      S_EXP_MUL: begin
        mm_start = 1'b1;
        mm_b     = NUM_WIDTH'(base_value(base_q));
        state_d  = S_W_MUL;
      end
      S_W_MUL: begin
        if (mm_stat.done) begin
          x_d     = mm_prod;
          state_d = S_EXP_NEXT;
        end
      end
      S_EXP_NEXT: begin
        e_d     = e_q << 1;
        i_d     = i_q - CW'(1);
        state_d = (i_q == CW'(1)) ? S_CHK : S_EXP_SQ;
      end
      S_CHK: begin
        if (x_q == NUM_WIDTH'(1) || x_q == nm1) begin
          state_d = S_NEXT_BASE;
        end else begin
          j_d     = CW'(1);
          state_d = S_LP_TEST;
        end
      end
      S_LP_TEST: begin
        if (j_q < s_q) begin
          mm_start = 1'b1;
          state_d  = S_W_LP;
        end else begin
          res_d   = 1'b0;
          state_d = S_DONE;
        end
      end
      S_W_LP: begin
        if (mm_stat.done) begin
          x_d = mm_prod;
          if (mm_prod == nm1) begin
            state_d = S_NEXT_BASE;
          end else begin
            j_d     = j_q + CW'(1);
            state_d = S_LP_TEST;
          end
        end
      end
      S_NEXT_BASE: begin
        res_d   = 1'b1;
        state_d = S_DONE;
        case (base_q)
          BASE_SEL_2: begin
            if (n_q > NUM_WIDTH'(BASE_SECOND)) begin
              base_d  = BASE_SEL_7;
              state_d = S_BASE;
            end
          end
          BASE_SEL_7: begin
            if (n_q > NUM_WIDTH'(BASE_THIRD)) begin
              base_d  = BASE_SEL_61;
              state_d = S_BASE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_prime_d = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q      <= base_d;
    n_q         <= n_d;
    d_q         <= d_d;
    x_q         <= x_d;
    e_q         <= e_d;
    s_q         <= s_d;
    i_q         <= i_d;
    j_q         <= j_d;
    res_q       <= res_d;
    out_prime_q <= out_prime_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign is_prime_o  = out_prime_q;

  `MRPT_ASSERT_IMP(a_mm_done_waited, mm_stat.done,
    state_q == S_W_SQ || state_q == S_W_MUL || state_q == S_W_LP,
    "product arrived outside a wait state")
  `MRPT_ASSERT_IMP(a_mm_start_idle, mm_start, !mm_stat.busy, "multiplier restarted while busy")
  `MRPT_ASSERT_IMP(a_out_from_done, $rose(out_valid_q), $past(state_q == S_DONE),
    "result beat not from done state")

endmodule

### tb/prime_verdict_checker.sv
// Checker for the primality tester: predicts each verdict and compares it on the output beat
module prime_verdict_checker import mrpt_pkg::*; #(
  parameter int unsigned NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [NUM_WIDTH-1:0] candidate_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 is_prime_i,
  output int unsigned          mismatches_o,
  output int unsigned          outstanding_o
);

  typedef struct packed {
    logic [NUM_WIDTH-1:0] cand;
    logic                 prime;
  } verdict_t;

  verdict_t    verdict_q [$];
  verdict_t    oldest;
  int unsigned fails;

  function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] n);
    return (a * b) % n;
  endfunction

  function automatic logic [63:0] pow_mod(input logic [63:0] b, input logic [63:0] e,
                                          input logic [63:0] n);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] ee;
    acc = 64'd1 % n;
    sq  = b % n;
    ee  = e;
    while (ee != 64'd0) begin
      if (ee[0]) acc = mul_mod(acc, sq, n);
      sq = mul_mod(sq, sq, n);
      ee = ee >> 1;
    end
    return acc;
  endfunction

  // strong probable prime round; n odd and at least 5
  function automatic logic passes_base(input logic [63:0] b, input logic [63:0] n);
    logic [63:0] d;
    logic [63:0] x;
    int          s;
    int          i;
    d = n - 64'd1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    x = pow_mod(b, d, n);
    if (x == 64'd1 || x == n - 64'd1) return 1'b1;
    for (i = 1; i < s; i++) begin
      x = mul_mod(x, x, n);
      if (x == n - 64'd1) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic prime_verdict(input logic [NUM_WIDTH-1:0] cand);
    logic [63:0] n;
    n = 64'(cand);
    if (n == 64'd2 || n == 64'd3) return 1'b1;
    if (n < 64'd2 || !n[0] || n % 64'd3 == 64'd0) return 1'b0;
    if (!passes_base(64'(BASE_FIRST), n)) return 1'b0;
    if (n > 64'(BASE_SECOND) && !passes_base(64'(BASE_SECOND), n)) return 1'b0;
    if (n > 64'(BASE_THIRD) && !passes_base(64'(BASE_THIRD), n)) return 1'b0;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what);
    if (fails < 10) $display("%s", what);
    fails++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // drain before fill: a result beat never belongs to a candidate taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result beat: is_prime expected none, got %0b",
                                  is_prime_i));
        end else begin
          oldest = verdict_q.pop_front();
          if (is_prime_i !== oldest.prime)
            note_mismatch($sformatf("candidate %0d: is_prime expected %0b, got %0b",
                                    oldest.cand, oldest.prime, is_prime_i));
        end
      end
      if (in_valid_i && !in_stall_i)
        verdict_q.push_back('{cand: candidate_i, prime: prime_verdict(candidate_i)});
      outstanding_o <= verdict_q.size();
      mismatches_o  <= fails;
    end
  end

endmodule

### tb/tb_miller_rabin_prime_test.sv
// Testbench top: candidate stimulus, stall pattern and final verdict for the primality tester
module tb_miller_rabin_prime_test import mrpt_pkg::*;;

  localparam int unsigned    NW               = NUM_WIDTH_DEF;
  localparam int unsigned    RANDOM_PER_PHASE = 500;
  localparam int unsigned    DRAIN_CYCLES     = 200;
  localparam longint unsigned CYCLE_LIMIT     = 64'd60_000_000;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [NW-1:0] candidate;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          is_prime;

  int unsigned     mismatches;
  int unsigned     outstanding;
  int unsigned     send_idle_pct  = 14;
  int unsigned     recv_stall_pct = 78;
  longint unsigned cycle_count    = 0;

  logic [NW-1:0] directed_cands [25] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd11, 32'd13,
    32'd25, 32'd49, 32'd61, 32'd67, 32'd121, 32'd561, 32'd2047, 32'd25326001,
    32'd3215031751, 32'd2147483647, 32'd4294967291, 32'd4294967279,
    32'd4293001441, 32'd4294967294, 32'd4294967295
  };

  logic [NW-1:0] small_primes [16] = '{
    32'd65521, 32'd65519, 32'd65497, 32'd65479, 32'd46337, 32'd32749, 32'd32719,
    32'd16381, 32'd8191, 32'd4093, 32'd2039, 32'd1021, 32'd509, 32'd251, 32'd127, 32'd97
  };

  logic [NW-1:0] big_primes [8] = '{
    32'd4294967291, 32'd4294967279, 32'd4294967197, 32'd2147483647,
    32'd2147483629, 32'd1000000007, 32'd998244353, 32'd3221225473
  };

  // base-2 strong pseudoprimes and Carmichael numbers
  logic [NW-1:0] pseudoprimes [16] = '{
    32'd2047, 32'd3277, 32'd4033, 32'd4681, 32'd8321, 32'd15841, 32'd29341, 32'd42799,
    32'd49141, 32'd52633, 32'd561, 32'd1105, 32'd1729, 32'd8911, 32'd25326001,
    32'd3215031751
  };

  miller_rabin_prime_test #(
    .NUM_WIDTH (NW)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .candidate_i (candidate),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .is_prime_o  (is_prime)
  );

  prime_verdict_checker #(
    .NUM_WIDTH (NW)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .candidate_i   (candidate),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .is_prime_i    (is_prime),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [NW-1:0] random_candidate();
    int unsigned   pick;
    logic [NW-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 25)
      v = $urandom;
    else if (pick < 40)
      v = NW'($urandom_range(5, 65535)) | NW'(1);
    else if (pick < 50)
      v = big_primes[$urandom_range(0, 7)];
    else if (pick < 55)
      v = small_primes[$urandom_range(0, 15)];
    else if (pick < 68)
      v = small_primes[$urandom_range(0, 15)] * small_primes[$urandom_range(0, 15)];
    else if (pick < 78)
      v = pseudoprimes[$urandom_range(0, 15)];
    else if (pick < 88)
      v = NW'($urandom_range(0, 32'd1431655765)) * NW'(3);
    else
      v = $urandom & ~NW'(1);
    return v;
  endfunction

  task automatic send_candidate(input logic [NW-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    candidate <= value;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    int phase;
    int k;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    candidate <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_cands[i]) send_candidate(directed_cands[i]);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 14;
          recv_stall_pct = 78;
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct = 14;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (k = 0; k < RANDOM_PER_PHASE; k++) send_candidate(random_candidate());
    end
    in_valid <= 1'b0;

    recv_stall_pct = 0;
    // let the count of the last accepted beat settle
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/mrpt_pkg.sv
sv/mrpt_modmul.sv
sv/miller_rabin_prime_test.sv
tb/prime_verdict_checker.sv
tb/tb_miller_rabin_prime_test.sv
